// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ACDV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ACDV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/acdv_pkg.sv
package acdv_pkg;

    localparam int unsigned FRAC_W   = 17;
    localparam int unsigned SCALED_W = 25;
    localparam int unsigned LEAD_W   = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned SCALE_W  = 8;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [FRAC_W-1:0]   FULL_UNITS   = 17'd100000;
    localparam logic [FRAC_W-1:0]   UNIT_10000   = 17'd10000;
    localparam logic [FRAC_W-1:0]   UNIT_1000    = 17'd1000;
    localparam logic [FRAC_W-1:0]   UNIT_100     = 17'd100;
    localparam logic [FRAC_W-1:0]   UNIT_10      = 17'd10;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 8'd50;

    // Register index taken from paddr word bit.
    localparam logic REG_REFERENCE_SCALE = 1'b0;

    typedef struct packed {
        logic [DIGIT_W-1:0]  q;
        logic [SCALED_W-1:0] r;
    } lead_step_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] q;
        logic [FRAC_W-1:0]  r;
    } digit_step_t;

    typedef struct packed {
        logic [SCALED_W-1:0] scaled;
        logic [LEAD_W-1:0]   lead;
        logic [DIGIT_W-1:0]  d_tt;
        logic [DIGIT_W-1:0]  d_th;
        logic [DIGIT_W-1:0]  d_h;
        logic [DIGIT_W-1:0]  d_t;
        logic [DIGIT_W-1:0]  d_u;
        logic [SCALED_W-1:0] rem;
    } acc_t;

    // Four restoring steps of the quotient by 100000; hi selects bits 7..4.
    function automatic lead_step_t lead_nibble(logic [SCALED_W-1:0] r, logic hi);
        lead_step_t          res;
        logic [SCALED_W-1:0] trial;
        res.r = r;
        res.q = '0;
        for (int i = 3; i >= 0; i--) begin
            trial = SCALED_W'(FULL_UNITS) << (i + (hi ? 4 : 0));
            if (res.r >= trial) begin
                res.r    = res.r - trial;
                res.q[i] = 1'b1;
            end
        end
        return res;
    endfunction

    // One decimal digit (0..9) of r against unit, r below 10*unit.
    function automatic digit_step_t dec_digit(logic [FRAC_W-1:0] r, logic [FRAC_W-1:0] unit);
        digit_step_t       res;
        logic [FRAC_W-1:0] trial;
        res.r = r;
        res.q = '0;
        for (int i = 3; i >= 0; i--) begin
            trial = unit << i;
            if (res.r >= trial) begin
                res.r    = res.r - trial;
                res.q[i] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// File: sv/adc_code_to_decimal_voltage.sv
// Converts a converter code to floor(code*100000/2^CODE_BITS)*reference_scale and splits
// that value into its quotient by 100000 and five decimal digits of the remainder.
// Eight register stages: code product, scale product, two stages of four quotient bits,
// then one stage per digit (tens and units share the last). One request per cycle is
// taken unless a stall has filled the pipeline. Each stage holds independently, so bubbles
// close up when the output is stalled. reference_scale is at APB word 0 (bytes 0 to 3).
module adc_code_to_decimal_voltage #(
    parameter int unsigned CODE_BITS = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [CODE_BITS-1:0]                 s_adc_code,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [acdv_pkg::SCALED_W-1:0]        m_scaled_value,
    output logic [acdv_pkg::LEAD_W-1:0]          m_lead_part,
    output logic [acdv_pkg::DIGIT_W-1:0]         m_digit_ten_thousands,
    output logic [acdv_pkg::DIGIT_W-1:0]         m_digit_thousands,
    output logic [acdv_pkg::DIGIT_W-1:0]         m_digit_hundreds,
    output logic [acdv_pkg::DIGIT_W-1:0]         m_digit_tens,
    output logic [acdv_pkg::DIGIT_W-1:0]         m_digit_units,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [acdv_pkg::PADDR_W-1:0]         paddr,
    input  logic [acdv_pkg::PDATA_W-1:0]         pwdata,
    output logic [acdv_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int unsigned PROD_W = CODE_BITS + acdv_pkg::FRAC_W;
    localparam int unsigned NSTG   = 8;

    // ---------------- configuration ----------------
    logic [acdv_pkg::SCALE_W-1:0] scale_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == acdv_pkg::REG_REFERENCE_SCALE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= acdv_pkg::SCALE_RESET;
        end else if (cfg_wr) begin
            scale_reg <= pwdata[acdv_pkg::SCALE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == acdv_pkg::REG_REFERENCE_SCALE) begin
            prdata = acdv_pkg::PDATA_W'(scale_reg);
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ---------------- datapath ----------------
    logic [PROD_W-1:0]            prod_reg;
    logic [acdv_pkg::FRAC_W-1:0]  frac;
    acdv_pkg::acc_t               acc_reg  [1:NSTG-1];
    acdv_pkg::acc_t               acc_next [1:NSTG-1];
    acdv_pkg::lead_step_t         ls_hi, ls_lo;
    acdv_pkg::digit_step_t        ds_tt, ds_th, ds_h, ds_t;

    assign frac = prod_reg[CODE_BITS +: acdv_pkg::FRAC_W];

    always_comb begin
        // scale product
        acc_next[1]        = '0;
        acc_next[1].scaled = acdv_pkg::SCALED_W'(frac) * acdv_pkg::SCALED_W'(scale_reg);
        acc_next[1].rem    = acc_next[1].scaled;

        // quotient bits 7..4
        ls_hi                 = acdv_pkg::lead_nibble(acc_reg[1].rem, 1'b1);
        acc_next[2]           = acc_reg[1];
        acc_next[2].lead[7:4] = ls_hi.q;
        acc_next[2].rem       = ls_hi.r;

        // quotient bits 3..0, remainder now below 100000
        ls_lo                 = acdv_pkg::lead_nibble(acc_reg[2].rem, 1'b0);
        acc_next[3]           = acc_reg[2];
        acc_next[3].lead[3:0] = ls_lo.q;
        acc_next[3].rem       = ls_lo.r;

        ds_tt            = acdv_pkg::dec_digit(acc_reg[3].rem[acdv_pkg::FRAC_W-1:0],
                                               acdv_pkg::UNIT_10000);
        acc_next[4]      = acc_reg[3];
        acc_next[4].d_tt = ds_tt.q;
        acc_next[4].rem  = acdv_pkg::SCALED_W'(ds_tt.r);

        ds_th            = acdv_pkg::dec_digit(acc_reg[4].rem[acdv_pkg::FRAC_W-1:0],
                                               acdv_pkg::UNIT_1000);
        acc_next[5]      = acc_reg[4];
        acc_next[5].d_th = ds_th.q;
        acc_next[5].rem  = acdv_pkg::SCALED_W'(ds_th.r);

        ds_h             = acdv_pkg::dec_digit(acc_reg[5].rem[acdv_pkg::FRAC_W-1:0],
                                               acdv_pkg::UNIT_100);
        acc_next[6]      = acc_reg[5];
        acc_next[6].d_h  = ds_h.q;
        acc_next[6].rem  = acdv_pkg::SCALED_W'(ds_h.r);

        // what is left after tens is the units digit
        ds_t             = acdv_pkg::dec_digit(acc_reg[6].rem[acdv_pkg::FRAC_W-1:0],
                                               acdv_pkg::UNIT_10);
        acc_next[7]      = acc_reg[6];
        acc_next[7].d_t  = ds_t.q;
        acc_next[7].d_u  = ds_t.r[acdv_pkg::DIGIT_W-1:0];
        acc_next[7].rem  = '0;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= PROD_W'(s_adc_code) * PROD_W'(acdv_pkg::FULL_UNITS);
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                acc_reg[k] <= acc_next[k];
            end
        end
    end

    assign m_scaled_value        = acc_reg[NSTG-1].scaled;
    assign m_lead_part           = acc_reg[NSTG-1].lead;
    assign m_digit_ten_thousands = acc_reg[NSTG-1].d_tt;
    assign m_digit_thousands     = acc_reg[NSTG-1].d_th;
    assign m_digit_hundreds      = acc_reg[NSTG-1].d_h;
    assign m_digit_tens          = acc_reg[NSTG-1].d_t;
    assign m_digit_units         = acc_reg[NSTG-1].d_u;

endmodule

// File: sv/acdv_checker.sv
`include "assert_macros.svh"

module acdv_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [acdv_pkg::SCALED_W-1:0]  m_scaled_value,
    input logic [acdv_pkg::LEAD_W-1:0]    m_lead_part,
    input logic [acdv_pkg::DIGIT_W-1:0]   m_digit_ten_thousands,
    input logic [acdv_pkg::DIGIT_W-1:0]   m_digit_thousands,
    input logic [acdv_pkg::DIGIT_W-1:0]   m_digit_hundreds,
    input logic [acdv_pkg::DIGIT_W-1:0]   m_digit_tens,
    input logic [acdv_pkg::DIGIT_W-1:0]   m_digit_units
);

    logic        digits_ok;
    logic [31:0] recomposed;

    assign digits_ok = (m_digit_ten_thousands <= 4'd9) && (m_digit_thousands <= 4'd9) &&
                       (m_digit_hundreds <= 4'd9) && (m_digit_tens <= 4'd9) &&
                       (m_digit_units <= 4'd9);

    assign recomposed = 32'(m_lead_part) * 32'd100000 + 32'(m_digit_ten_thousands) * 32'd10000 +
                        32'(m_digit_thousands) * 32'd1000 + 32'(m_digit_hundreds) * 32'd100 +
                        32'(m_digit_tens) * 32'd10 + 32'(m_digit_units);

    `ACDV_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `ACDV_ASSERT(a_valid_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")
    `ACDV_ASSERT(a_value_holds, aclk, aresetn, m_valid && !m_ready |=> $stable(m_scaled_value), "stalled value changed")
    `ACDV_ASSERT(a_digits_range, aclk, aresetn, m_valid |-> digits_ok, "digit above nine")
    `ACDV_ASSERT(a_split_matches, aclk, aresetn, m_valid |-> (recomposed == 32'(m_scaled_value)), "split does not recompose value")

endmodule

bind adc_code_to_decimal_voltage acdv_checker u_acdv_checker (.*);

// File: tb/sv/tb_top.sv
module tb_top;

    localparam int unsigned CODE_BITS    = 12;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned FULL_SCALE   = 100000;

    // Register 0 sits at word 0; bits 1..0 of paddr are a byte offset.
    localparam logic [acdv_pkg::PADDR_W-1:0] ADDR_SCALE      = 3'd0;
    localparam logic [acdv_pkg::PADDR_W-1:0] ADDR_SCALE_BYTE = 3'd3;
    localparam logic [acdv_pkg::PADDR_W-1:0] ADDR_SPARE      = 3'd4;
    localparam logic [acdv_pkg::PADDR_W-1:0] ADDR_SPARE_BYTE = 3'd7;

    typedef struct packed {
        logic [acdv_pkg::SCALED_W-1:0] scaled;
        logic [acdv_pkg::LEAD_W-1:0]   lead;
        logic [acdv_pkg::DIGIT_W-1:0]  d_tt;
        logic [acdv_pkg::DIGIT_W-1:0]  d_th;
        logic [acdv_pkg::DIGIT_W-1:0]  d_h;
        logic [acdv_pkg::DIGIT_W-1:0]  d_t;
        logic [acdv_pkg::DIGIT_W-1:0]  d_u;
    } reading_t;

    class voltage_scoreboard;
        logic [acdv_pkg::SCALE_W-1:0] ref_scale;
        reading_t                     pending_readings[$];
        int                           n_err;

        function new();
            ref_scale = acdv_pkg::SCALE_RESET;
            n_err     = 0;
        endfunction

        function void write_reg(logic [acdv_pkg::PADDR_W-1:0] addr,
                                logic [acdv_pkg::PDATA_W-1:0] data);
            if (addr[2] == acdv_pkg::REG_REFERENCE_SCALE) begin
                ref_scale = data[acdv_pkg::SCALE_W-1:0];
            end
        endfunction

        function reading_t predict_reading(logic [CODE_BITS-1:0] code);
            reading_t    r;
            int unsigned frac;
            int unsigned v;
            int unsigned rest;
            frac   = (32'(code) * FULL_SCALE) >> CODE_BITS;
            v      = frac * 32'(ref_scale);
            r.scaled = v[acdv_pkg::SCALED_W-1:0];
            r.lead   = acdv_pkg::LEAD_W'(v / FULL_SCALE);
            rest     = v % FULL_SCALE;
            r.d_tt   = acdv_pkg::DIGIT_W'(rest / 10000);
            rest     = rest % 10000;
            r.d_th   = acdv_pkg::DIGIT_W'(rest / 1000);
            rest     = rest % 1000;
            r.d_h    = acdv_pkg::DIGIT_W'(rest / 100);
            rest     = rest % 100;
            r.d_t    = acdv_pkg::DIGIT_W'(rest / 10);
            r.d_u    = acdv_pkg::DIGIT_W'(rest % 10);
            return r;
        endfunction

        function void note_code(logic [CODE_BITS-1:0] code);
            pending_readings.push_back(predict_reading(code));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                n_err++;
            end
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (pending_readings.size() == 0) begin
                $error("unexpected result: scaled_value %0d", got.scaled);
                n_err++;
            end else begin
                want = pending_readings.pop_front();
                compare_field("scaled_value", want.scaled, got.scaled);
                compare_field("lead_part", want.lead, got.lead);
                compare_field("digit_ten_thousands", want.d_tt, got.d_tt);
                compare_field("digit_thousands", want.d_th, got.d_th);
                compare_field("digit_hundreds", want.d_h, got.d_h);
                compare_field("digit_tens", want.d_t, got.d_t);
                compare_field("digit_units", want.d_u, got.d_u);
            end
        endfunction
    endclass

    logic                                   aclk;
    logic                                   aresetn;
    logic                                   s_valid;
    logic                                   s_ready;
    logic [CODE_BITS-1:0]                   s_adc_code;
    logic                                   m_valid;
    logic                                   m_ready;
    logic [acdv_pkg::SCALED_W-1:0]          m_scaled_value;
    logic [acdv_pkg::LEAD_W-1:0]            m_lead_part;
    logic [acdv_pkg::DIGIT_W-1:0]           m_digit_ten_thousands;
    logic [acdv_pkg::DIGIT_W-1:0]           m_digit_thousands;
    logic [acdv_pkg::DIGIT_W-1:0]           m_digit_hundreds;
    logic [acdv_pkg::DIGIT_W-1:0]           m_digit_tens;
    logic [acdv_pkg::DIGIT_W-1:0]           m_digit_units;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [acdv_pkg::PADDR_W-1:0]           paddr;
    logic [acdv_pkg::PDATA_W-1:0]           pwdata;
    logic [acdv_pkg::PDATA_W-1:0]           prdata;
    logic                                   pready;

    voltage_scoreboard sb;
    int unsigned       idle_pct  = 38;
    int unsigned       stall_pct = 38;
    int unsigned       cycle_count = 0;

    adc_code_to_decimal_voltage #(
        .CODE_BITS(CODE_BITS)
    ) u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_adc_code            (s_adc_code),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_scaled_value        (m_scaled_value),
        .m_lead_part           (m_lead_part),
        .m_digit_ten_thousands (m_digit_ten_thousands),
        .m_digit_thousands     (m_digit_thousands),
        .m_digit_hundreds      (m_digit_hundreds),
        .m_digit_tens          (m_digit_tens),
        .m_digit_units         (m_digit_units),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready = aresetn && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_code(s_adc_code);
            end
            if (m_valid && m_ready) begin
                sb.check_reading('{m_scaled_value, m_lead_part, m_digit_ten_thousands,
                                   m_digit_thousands, m_digit_hundreds, m_digit_tens,
                                   m_digit_units});
            end
        end
    end

    // All tasks are entered and left at a falling edge.
    task automatic send_code(logic [CODE_BITS-1:0] code);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_adc_code = code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic apb_write(logic [acdv_pkg::PADDR_W-1:0] addr,
                             logic [acdv_pkg::PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(addr, data);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_scale_readback();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_SCALE;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[acdv_pkg::SCALE_W-1:0] !== sb.ref_scale) begin
            $error("reference_scale: expected %0d, actual %0d", sb.ref_scale,
                   prdata[acdv_pkg::SCALE_W-1:0]);
            sb.n_err++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Block is idle once every request has produced its reading.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.pending_readings.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [CODE_BITS-1:0] pick_code();
        logic [CODE_BITS-1:0] edges[6] = '{0, 1, 2047, 2048, 4094, 4095};
        if ($urandom_range(99) < 20) begin
            return edges[$urandom_range(5)];
        end
        return CODE_BITS'($urandom);
    endfunction

    task automatic random_phase(int n_items, logic [acdv_pkg::PDATA_W-1:0] scale_word);
        wait_idle();
        apb_write(ADDR_SCALE, scale_word);
        check_scale_readback();
        repeat (n_items) send_code(pick_code());
    endtask

    initial begin
        sb         = new();
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_adc_code = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset multiplier
        check_scale_readback();
        send_code(12'd0);
        send_code(12'd4095);
        send_code(12'd1);
        send_code(12'd2048);

        // largest multiplier: top of the lead_part range
        wait_idle();
        apb_write(ADDR_SCALE, 32'd255);
        check_scale_readback();
        send_code(12'd4095);
        send_code(12'd0);
        send_code(12'd4094);
        send_code(12'd1);
        send_code(12'd2731);

        wait_idle();
        apb_write(ADDR_SCALE, 32'd0);
        check_scale_readback();
        send_code(12'd4095);
        send_code(12'd1234);

        // upper data bits dropped, byte offset within the word ignored
        wait_idle();
        apb_write(ADDR_SCALE_BYTE, 32'hffff_ff01);
        check_scale_readback();
        send_code(12'd4095);
        send_code(12'd41);

        // writes to the unmapped word must leave the multiplier alone
        wait_idle();
        apb_write(ADDR_SPARE, 32'h0000_0007);
        apb_write(ADDR_SPARE_BYTE, 32'hffff_fff8);
        check_scale_readback();
        send_code(12'd4095);

        wait_idle();
        apb_write(ADDR_SCALE, 32'd200);
        check_scale_readback();
        send_code(12'd4095);
        send_code(12'd2047);
        send_code(12'd3000);

        random_phase(100, 32'd255);
        random_phase(100, $urandom);
        idle_pct  = 0;
        stall_pct = 0;
        random_phase(120, $urandom);
        idle_pct  = 38;
        stall_pct = 38;
        random_phase(100, $urandom);
        random_phase(80, $urandom);

        wait_idle();
        if (sb.n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: adc_code_to_decimal_voltage.f
+incdir+sv
sv/acdv_pkg.sv
sv/adc_code_to_decimal_voltage.sv
sv/acdv_checker.sv
tb/sv/tb_top.sv
